[design/sosc_pkg.sv]
// Shared constants for the sine oscillator.
package sosc_pkg;

   localparam int PHASE_BITS_DEFAULT      = 32;
   localparam int OUT_BITS_DEFAULT        = 16;
   localparam int TABLE_ADDR_BITS_DEFAULT = 10;

   localparam int STEP_BITS = 32;

   // pi/2 in Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

[design/sosc_req_if.sv]
// Request channel: one sample tick with its restart flag.
interface sosc_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

[design/sosc_rsp_if.sv]
// Response channel: one signed sine sample.
interface sosc_rsp_if import sosc_pkg::*; #(
   parameter int OUT_BITS = OUT_BITS_DEFAULT
);
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[design/sosc_phase.sv]
// Phase accumulator, step register and quadrant/table address stage.
module sosc_phase import sosc_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   sosc_req_if.sink                 req,
   input  logic                     csr_we,
   input  logic [STEP_BITS-1:0]     csr_wdata,
   input  logic                     pipe_en,
   output logic                     s1_valid,
   output logic                     s1_neg,
   output logic [TABLE_ADDR_BITS:0] s1_addr
);

   localparam logic [TABLE_ADDR_BITS:0] TAB_TOP = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

   logic [STEP_BITS-1:0]       step_ff;
   logic [PHASE_BITS-1:0]      acc_ff;
   logic [PHASE_BITS-1:0]      acc_in;
   logic [PHASE_BITS-1:0]      phase_now;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] fine;
   logic [TABLE_ADDR_BITS:0]   addr_in;
   logic                       accept;
   logic                       valid_ff;
   logic                       neg_ff;
   logic [TABLE_ADDR_BITS:0]   addr_ff;

   assign req.ready = pipe_en;
   assign accept    = req.valid && pipe_en;

   assign phase_now = req.restart ? '0 : acc_ff;
   assign acc_in    = phase_now + PHASE_BITS'(step_ff);
   assign quad      = phase_now[PHASE_BITS-1 -: 2];
   assign fine      = phase_now[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   assign addr_in   = quad[0] ? (TAB_TOP - {1'b0, fine}) : {1'b0, fine};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
         if (accept) begin
            acc_ff <= acc_in;
         end
         if (pipe_en) begin
            valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff  <= quad[1];
         addr_ff <= addr_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_neg   = neg_ff;
   assign s1_addr  = addr_ff;

endmodule

[design/sosc_rom.sv]
// Quarter-wave sine ROM with registered read.
module sosc_rom import sosc_pkg::*; #(
   parameter int OUT_BITS        = OUT_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pipe_en,
   input  logic                     s1_valid,
   input  logic                     s1_neg,
   input  logic [TABLE_ADDR_BITS:0] s1_addr,
   output logic                     s2_valid,
   output logic                     s2_neg,
   output logic [OUT_BITS-2:0]      s2_mag
);

   localparam int MAG_BITS = OUT_BITS - 1;
   localparam int TAB_LEN  = (1 << TABLE_ADDR_BITS) + 1;

   typedef logic [MAG_BITS-1:0] tab_type [TAB_LEN];

   // Q30 Taylor series of sine, odd terms through x^17
   function automatic tab_type build_tab();
      tab_type     t;
      longint      sum;
      logic [63:0] term;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] full;
      full = (64'd1 << (OUT_BITS - 1)) - 64'd1;
      for (int a = 0; a < TAB_LEN; a++) begin
         x = (64'(a) * HALF_PI_Q30 + ((64'd1 << TABLE_ADDR_BITS) >> 1)) >> TABLE_ADDR_BITS;
         sum  = longint'(x);
         term = x;
         for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         s = 64'(sum);
         v = ((s << (OUT_BITS - 1)) + (64'd1 << 29)) >> 30;
         t[a] = (v > full) ? MAG_BITS'(full) : MAG_BITS'(v);
      end
      return t;
   endfunction

   localparam tab_type QTAB = build_tab();

   logic                valid_ff;
   logic                neg_ff;
   logic [MAG_BITS-1:0] mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         neg_ff <= s1_neg;
         mag_ff <= QTAB[s1_addr];
      end
   end

   assign s2_valid = valid_ff;
   assign s2_neg   = neg_ff;
   assign s2_mag   = mag_ff;

endmodule

[design/sosc_out.sv]
// Sign application, output register and skid register.
module sosc_out import sosc_pkg::*; #(
   parameter int OUT_BITS = OUT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                s2_valid,
   input  logic                s2_neg,
   input  logic [OUT_BITS-2:0] s2_mag,
   output logic                pipe_en,
   sosc_rsp_if.source          rsp
);

   logic                       out_v_ff;
   logic signed [OUT_BITS-1:0] out_data_ff;
   logic                       skid_v_ff;
   logic signed [OUT_BITS-1:0] skid_data_ff;
   logic signed [OUT_BITS-1:0] result;
   logic                       arrive;
   logic                       out_free;

   assign pipe_en  = !skid_v_ff;
   assign arrive   = s2_valid && pipe_en;
   assign out_free = !out_v_ff || rsp.ready;
   assign result   = s2_neg ? -$signed({1'b0, s2_mag}) : $signed({1'b0, s2_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp.ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (out_free) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp.ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (arrive) begin
         if (out_free) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp.valid  = out_v_ff;
   assign rsp.sample = out_data_ff;

endmodule

[design/sine_oscillator.sv]
// Sine oscillator top level: phase accumulator, quarter-wave ROM, output stage.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        restart
//   rsp      out        valid/ready        sample (signed OUT_BITS)
//   csr      in         csr_we             csr_wdata = phase step
//
// One request per cycle while the skid register is empty. After acceptance a
// request passes the phase register, the registered ROM read and the output
// register before rsp.valid rises and the response can be taken.
// Reset clears the phase accumulator, the phase step and all valid flags.
// A stalled response is caught in a skid register; req.ready drops from the
// edge that fills it and the whole pipeline holds until the skid drains.
module sine_oscillator import sosc_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEFAULT,
   parameter int OUT_BITS        = OUT_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   sosc_req_if.sink             req_if,
   sosc_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [STEP_BITS-1:0] csr_wdata
);

   logic                     pipe_en;
   logic                     s1_valid;
   logic                     s1_neg;
   logic [TABLE_ADDR_BITS:0] s1_addr;
   logic                     s2_valid;
   logic                     s2_neg;
   logic [OUT_BITS-2:0]      s2_mag;

   sosc_phase #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pipe_en   (pipe_en),
      .s1_valid  (s1_valid),
      .s1_neg    (s1_neg),
      .s1_addr   (s1_addr)
   );

   sosc_rom #(
      .OUT_BITS        (OUT_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock    (clock),
      .reset    (reset),
      .pipe_en  (pipe_en),
      .s1_valid (s1_valid),
      .s1_neg   (s1_neg),
      .s1_addr  (s1_addr),
      .s2_valid (s2_valid),
      .s2_neg   (s2_neg),
      .s2_mag   (s2_mag)
   );

   sosc_out #(
      .OUT_BITS (OUT_BITS)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .s2_valid (s2_valid),
      .s2_neg   (s2_neg),
      .s2_mag   (s2_mag),
      .pipe_en  (pipe_en),
      .rsp      (rsp_if)
   );

endmodule

[tb/tb_top.sv]
// Testbench for sine_oscillator: tone prediction, bursty requests, stalled responses.
module tb_top;
   import sosc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_W = PHASE_BITS_DEFAULT;
   localparam int OUT_W   = OUT_BITS_DEFAULT;
   localparam int ADDR_W  = TABLE_ADDR_BITS_DEFAULT;
   localparam int TAB_TOP = 1 << ADDR_W;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [STEP_BITS-1:0] csr_wdata;

   sosc_req_if                   req ();
   sosc_rsp_if #(.OUT_BITS(OUT_W)) rsp ();

   sine_oscillator #(
      .PHASE_BITS      (PHASE_W),
      .OUT_BITS        (OUT_W),
      .TABLE_ADDR_BITS (ADDR_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tone model
   logic signed [OUT_W-1:0] quarter_wave [0:TAB_TOP];
   logic [PHASE_W-1:0]      tone_phase;
   logic [STEP_BITS-1:0]    tone_step;
   logic signed [OUT_W-1:0] pending_samples [$];

   int mismatch_count = 0;
   int burst_left     = 0;
   int hold_len       = 0;
   int hold_seq       = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic signed [OUT_W-1:0] sine_of_phase(input logic [PHASE_W-1:0] phase);
      logic [1:0]              quad;
      logic [ADDR_W:0]         idx;
      logic signed [OUT_W-1:0] mag;
      quad = phase[PHASE_W-1 -: 2];
      idx  = {1'b0, phase[PHASE_W-3 -: ADDR_W]};
      if (quad[0]) begin
         idx = (ADDR_W + 1)'(TAB_TOP) - idx;
      end
      mag = quarter_wave[idx];
      return quad[1] ? -mag : mag;
   endfunction

   // one request at a falling edge; returns at a falling edge with valid still high
   task automatic send_tick(input bit restart);
      req.valid   <= 1'b1;
      req.restart <= restart;
      do @(posedge clock); while (!req.ready);
      if (restart) begin
         tone_phase = '0;
      end
      pending_samples.push_back(sine_of_phase(tone_phase));
      tone_phase = tone_phase + tone_step;
      @(negedge clock);
   endtask

   task automatic stop_offer();
      req.valid   <= 1'b0;
      req.restart <= 1'($urandom);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0) @(negedge clock);
   endtask

   task automatic set_step(input logic [STEP_BITS-1:0] value);
      wait_drained();
      repeat (6) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      tone_step  = value;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= STEP_BITS'($urandom);
   endtask

   // bursts of random length with random gaps; restart on about one request in odds
   task automatic send_ticks(input int count, input int odds);
      int gap;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && i > 0) begin
               stop_offer();
               repeat (gap) @(negedge clock);
            end
         end
         send_tick(odds > 0 && $urandom_range(0, odds - 1) == 0);
         burst_left--;
      end
      stop_offer();
   endtask

   task automatic test_zero_step();
      set_step('0);
      send_tick(1'b0);
      send_tick(1'b1);
      stop_offer();
   endtask

   task automatic test_quarter_turn();
      set_step(32'h4000_0000);
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      stop_offer();
   endtask

   task automatic test_step_extremes();
      set_step('1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      stop_offer();
      set_step(32'h8000_0000);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      stop_offer();
      set_step(32'h0010_0000);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      stop_offer();
   endtask

   task automatic test_random_tones(input int total);
      int                   sent;
      int                   n;
      logic [STEP_BITS-1:0] step;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 5))
            0:       step = STEP_BITS'($urandom_range(1, 65535));
            1:       step = '1 - STEP_BITS'($urandom_range(0, 65535));
            2:       step = STEP_BITS'(1) << $urandom_range(0, STEP_BITS - 1);
            default: step = STEP_BITS'($urandom);
         endcase
         n = $urandom_range(20, 100);
         if (n > total - sent) begin
            n = total - sent;
         end
         set_step(step);
         send_ticks(n, $urandom_range(0, 1) ? 16 : 0);
         sent += n;
      end
   endtask

   // response side held off while requests keep coming, then a full drain
   task automatic test_output_stall();
      set_step(STEP_BITS'($urandom));
      hold_len = 80;
      hold_seq++;
      send_tick(1'b1);
      repeat (39) send_tick(1'b0);
      stop_offer();
      wait_drained();
      hold_len = 120;
      hold_seq++;
      send_ticks(40, 8);
      wait_drained();
   endtask

   // response ready: mixed stall patterns plus requested long hold-offs
   initial begin : rsp_ready_driver
      int mode;
      int left;
      int hold_left;
      int hold_seen;
      mode      = 0;
      left      = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 150);
         end
         left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp.ready <= 1'b1;
               1:       rsp.ready <= 1'($urandom_range(0, 1));
               2:       rsp.ready <= (left % 3 == 0);
               default: rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_sample
      logic signed [OUT_W-1:0] want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d", rsp.sample));
         end else begin
            want = pending_samples.pop_front();
            if (rsp.sample !== want) begin
               report_mismatch($sformatf("sample %0d, expected %0d", rsp.sample, want));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL sine_oscillator");
      $finish;
   end

   initial begin : main_seq
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req.valid   = 1'b0;
      req.restart = 1'b0;
      tone_phase  = '0;
      tone_step   = '0;

      // quarter-wave table: Q30 Taylor series, scaled and rounded
      for (int a = 0; a <= TAB_TOP; a++) begin
         x    = (64'(a) * HALF_PI_Q30 + 64'(TAB_TOP / 2)) >> ADDR_W;
         sum  = longint'(x);
         term = x;
         for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = ((64'(sum) << (OUT_W - 1)) + (64'd1 << 29)) >> 30;
         if (v > 64'((1 << (OUT_W - 1)) - 1)) begin
            v = 64'((1 << (OUT_W - 1)) - 1);
         end
         quarter_wave[a] = OUT_W'(v);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_zero_step();
      test_quarter_turn();
      test_step_extremes();
      test_random_tones(450);
      test_output_stall();
      test_random_tones(420);

      for (int n = 0; n < 20000 && pending_samples.size() != 0; n++) @(negedge clock);
      repeat (10) @(negedge clock);
      if (pending_samples.size() != 0) begin
         report_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));
      end
      if (mismatch_count == 0) begin
         $display("PASS sine_oscillator");
      end else begin
         $display("FAIL sine_oscillator");
      end
      $finish;
   end

endmodule

[files.f]
design/sosc_pkg.sv
design/sosc_req_if.sv
design/sosc_rsp_if.sv
design/sosc_phase.sv
design/sosc_rom.sv
design/sosc_out.sv
design/sine_oscillator.sv
tb/tb_top.sv
